// ===== src/cops_pkg.sv =====
// Shared constants, types and sine table for the coupled oscillator phase step block.
package cops_pkg;

   localparam int MAX_OSC         = 64;
   localparam int SINE_TABLE_BITS = 10;

   localparam int OSC_FIELD_W = 6;
   localparam int VALUE_W     = 17;
   localparam int MASK_W      = 64;
   localparam int PHASE_W     = 16;
   localparam int GAIN_W      = 16;
   localparam int DRIFT_W     = 16;

   localparam int IDX_W = $clog2(MAX_OSC);
   localparam int CNT_W = $clog2(MAX_OSC + 1);
   localparam int ACC_W = PHASE_W + $clog2(MAX_OSC);

   localparam int SINE_SHIFT = PHASE_W - SINE_TABLE_BITS;
   localparam int SINE_QBITS = SINE_TABLE_BITS - 2;
   localparam int SINE_QTR   = 1 << SINE_QBITS;
   localparam int MAG_W      = 15;
   localparam int TERM_W     = MAG_W + 1;

   localparam longint SIN_C1 = 51459;
   localparam longint SIN_C3 = 21060;
   localparam longint SIN_C5 = 2369;
   localparam longint SIN_ONE = 16384;
   localparam longint MAG_MAX = 32767;

   localparam int INV_TWO_PI = 10430;
   localparam int INV_W      = 14;
   localparam int GK_W       = GAIN_W + INV_W;
   localparam int PROD_W     = GK_W + 1 + ACC_W;
   localparam int RND_SHIFT  = 31;
   localparam int RND_W      = PROD_W - RND_SHIFT + 1;
   localparam longint RND_BIAS = longint'(1) << (RND_SHIFT - 1);
   localparam int DRIFT_MAX  = 32767;
   localparam int DRIFT_MIN  = -32768;

   typedef logic [MAG_W-1:0] sine_tbl_type [SINE_QTR];

   typedef struct packed {
      logic clear;
      logic tap;
   } sine_ctl_type;

   typedef struct packed {
      logic mul;
      logic rnd;
   } drift_ctl_type;

   function automatic logic [MAG_W-1:0] sine_mag(input longint x);
      longint x2;
      longint x3;
      longint x5;
      longint s;
      x2 = (x * x) >>> 14;
      x3 = (x2 * x) >>> 14;
      x5 = (x3 * x2) >>> 14;
      s  = (SIN_C1 * x - SIN_C3 * x3 + SIN_C5 * x5) >>> 14;
      if (s > MAG_MAX) s = MAG_MAX;
      if (s < 0) s = 0;
      return s[MAG_W-1:0];
   endfunction

   function automatic sine_tbl_type build_sine_tbl();
      sine_tbl_type t;
      for (int k = 0; k < SINE_QTR; k++) begin
         t[k] = sine_mag(longint'(k) << SINE_SHIFT);
      end
      return t;
   endfunction

   localparam sine_tbl_type SINE_TBL = build_sine_tbl();
   localparam logic [MAG_W-1:0] SINE_FULL = sine_mag(SIN_ONE);

endpackage

// ===== src/cops_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cops_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/cops_sine_acc.sv =====
// Sine table lookup of a phase difference and the shared coupling accumulator.
module cops_sine_acc (
   input  logic                              clock,
   input  logic                              reset,
   input  cops_pkg::sine_ctl_type            ctl,
   input  logic [cops_pkg::PHASE_W-1:0]      phase_self,
   input  logic [cops_pkg::PHASE_W-1:0]      phase_nbr,
   output logic signed [cops_pkg::ACC_W-1:0] acc
);

   logic [cops_pkg::PHASE_W-1:0]       diff;
   logic [1:0]                         quad;
   logic [cops_pkg::SINE_QBITS-1:0]    k;
   logic [cops_pkg::SINE_QBITS-1:0]    k_idx;
   logic                               full;
   logic [cops_pkg::MAG_W-1:0]         mag;
   logic signed [cops_pkg::TERM_W-1:0] term_in;
   logic signed [cops_pkg::TERM_W-1:0] term_ff;
   logic                               term_vld_in;
   logic                               term_vld_ff;
   logic signed [cops_pkg::ACC_W-1:0]  acc_in;
   logic signed [cops_pkg::ACC_W-1:0]  acc_ff;

   assign diff  = phase_self - phase_nbr;
   assign quad  = diff[cops_pkg::PHASE_W-1 -: 2];
   assign k     = diff[cops_pkg::PHASE_W-3:cops_pkg::SINE_SHIFT];
   assign k_idx = quad[0] ? (~k + cops_pkg::SINE_QBITS'(1)) : k;
   assign full  = quad[0] && (k == '0);
   assign mag   = full ? cops_pkg::SINE_FULL : cops_pkg::SINE_TBL[k_idx];

   always_comb begin
      term_in = $signed({1'b0, mag});
      if (quad[1]) begin
         term_in = -$signed({1'b0, mag});
      end
      term_vld_in = ctl.tap && !ctl.clear;
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (term_vld_ff) begin
         acc_in = acc_ff + cops_pkg::ACC_W'(term_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_vld_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         term_vld_ff <= term_vld_in;
         acc_ff      <= acc_in;
      end
      term_ff <= term_in;
   end

   assign acc = acc_ff;

endmodule

// ===== src/cops_drift.sv =====
// Gain multiply, rounding and saturation of the coupling sum into a drift step.
module cops_drift (
   input  logic                                clock,
   input  cops_pkg::drift_ctl_type             ctl,
   input  logic [cops_pkg::GAIN_W-1:0]         gain,
   input  logic signed [cops_pkg::ACC_W-1:0]   acc,
   output logic signed [cops_pkg::DRIFT_W-1:0] drift
);

   logic [cops_pkg::GK_W-1:0]           gk_in;
   logic [cops_pkg::GK_W-1:0]           gk_ff;
   logic signed [cops_pkg::PROD_W-1:0]  prod_in;
   logic signed [cops_pkg::PROD_W-1:0]  prod_ff;
   logic signed [cops_pkg::PROD_W:0]    rnd_sum;
   logic signed [cops_pkg::RND_W-1:0]   rnd_q;
   logic signed [cops_pkg::DRIFT_W-1:0] drift_in;
   logic signed [cops_pkg::DRIFT_W-1:0] drift_ff;

   assign gk_in   = cops_pkg::GK_W'(gain) * cops_pkg::GK_W'(cops_pkg::INV_TWO_PI);
   assign prod_in = cops_pkg::PROD_W'($signed({1'b0, gk_ff})) * cops_pkg::PROD_W'(acc);
   assign rnd_sum = -((cops_pkg::PROD_W + 1)'(prod_ff))
                    + (cops_pkg::PROD_W + 1)'(cops_pkg::RND_BIAS);
   assign rnd_q   = rnd_sum[cops_pkg::PROD_W:cops_pkg::RND_SHIFT];

   always_comb begin
      priority if (rnd_q > cops_pkg::RND_W'(cops_pkg::DRIFT_MAX)) begin
         drift_in = cops_pkg::DRIFT_W'(cops_pkg::DRIFT_MAX);
      end else if (rnd_q < cops_pkg::RND_W'(cops_pkg::DRIFT_MIN)) begin
         drift_in = cops_pkg::DRIFT_W'(cops_pkg::DRIFT_MIN);
      end else begin
         drift_in = rnd_q[cops_pkg::DRIFT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      gk_ff <= gk_in;
      if (ctl.mul) begin
         prod_ff <= prod_in;
      end
      if (ctl.rnd) begin
         drift_ff <= drift_in;
      end
   end

   assign drift = drift_ff;

endmodule

// ===== src/coupled_oscillator_phase_step_top.sv =====
// Top level of the coupled oscillator phase step: sequencer, phase buffers and result register.
//
//   channel | ports                         | transfer when
//   --------+-------------------------------+------------------------------
//   request | req_valid, req_stall, req_*   | req_valid && !req_stall
//   result  | rsp_valid, rsp_stall, rsp_*   | rsp_valid && !rsp_stall
//   config  | csr_wr_en, csr_wr_data        | csr_wr_en
//
// Load item: a transfer runs the self-phase read (S_RD_SELF, S_GET_SELF), then S_FINISH.
// Update item: after the self-phase read, one old-buffer read and one sine lookup per
// oscillator through the shared accumulator, then S_DRAIN, S_MUL, S_ROUND and S_FINISH.
// end_of_step then copies the new buffer into the old one in S_COPY, one entry a cycle through
// the buffer RAM ports. After reset a clearing pass zeroes both buffers; no request is taken.
// A stalled result holds in the output register; the next request waits until it is taken.
module coupled_oscillator_phase_step_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_mode,
   input  logic [cops_pkg::OSC_FIELD_W-1:0]    req_osc_index,
   input  logic signed [cops_pkg::VALUE_W-1:0] req_value,
   input  logic [cops_pkg::MASK_W-1:0]         req_neighbor_mask,
   input  logic                                req_end_of_step,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [cops_pkg::PHASE_W-1:0]        rsp_phase_before,
   output logic signed [cops_pkg::DRIFT_W-1:0] rsp_drift_step,
   output logic [cops_pkg::PHASE_W-1:0]        rsp_phase_after,
   input  logic                                csr_wr_en,
   input  logic [cops_pkg::GAIN_W-1:0]         csr_wr_data
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_RD_SELF,
      S_GET_SELF,
      S_LOOP,
      S_DRAIN,
      S_MUL,
      S_ROUND,
      S_FINISH,
      S_COPY
   } state_type;

   state_type state_in, state_ff;

   logic [cops_pkg::CNT_W-1:0]   cnt_in, cnt_ff;
   logic                         tap_in, tap_ff;
   logic                         cp_pend_in, cp_pend_ff;
   logic [cops_pkg::IDX_W-1:0]   cp_addr_in, cp_addr_ff;
   logic                         rsp_valid_in, rsp_valid_ff;
   logic [cops_pkg::GAIN_W-1:0]  gain_ff;

   logic                         mode_ff;
   logic [cops_pkg::IDX_W-1:0]   idx_ff;
   logic                         idx_ok_ff;
   logic [cops_pkg::PHASE_W-1:0] noise_ff;
   logic [cops_pkg::MAX_OSC-1:0] mask_ff;
   logic                         eos_ff;
   logic [cops_pkg::PHASE_W-1:0] before_in, before_ff;

   logic [cops_pkg::PHASE_W-1:0]        rsp_before_in, rsp_before_ff;
   logic signed [cops_pkg::DRIFT_W-1:0] rsp_drift_in, rsp_drift_ff;
   logic [cops_pkg::PHASE_W-1:0]        rsp_after_in, rsp_after_ff;

   logic                         accept;
   logic                         cnt_done;

   logic                         old_we;
   logic [cops_pkg::IDX_W-1:0]   old_waddr;
   logic [cops_pkg::PHASE_W-1:0] old_wdata;
   logic [cops_pkg::IDX_W-1:0]   old_raddr;
   logic [cops_pkg::PHASE_W-1:0] old_rdata;
   logic                         new_we;
   logic [cops_pkg::IDX_W-1:0]   new_waddr;
   logic [cops_pkg::PHASE_W-1:0] new_wdata;
   logic [cops_pkg::IDX_W-1:0]   new_raddr;
   logic [cops_pkg::PHASE_W-1:0] new_rdata;

   cops_pkg::sine_ctl_type              sine_ctl;
   cops_pkg::drift_ctl_type             drift_ctl;
   logic signed [cops_pkg::ACC_W-1:0]   acc;
   logic signed [cops_pkg::DRIFT_W-1:0] drift;

   cops_ram #(
      .WIDTH(cops_pkg::PHASE_W),
      .DEPTH(cops_pkg::MAX_OSC)
   ) u_old_ram (
      .clock  (clock),
      .wr_en  (old_we),
      .wr_addr(old_waddr),
      .wr_data(old_wdata),
      .rd_addr(old_raddr),
      .rd_data(old_rdata)
   );

   cops_ram #(
      .WIDTH(cops_pkg::PHASE_W),
      .DEPTH(cops_pkg::MAX_OSC)
   ) u_new_ram (
      .clock  (clock),
      .wr_en  (new_we),
      .wr_addr(new_waddr),
      .wr_data(new_wdata),
      .rd_addr(new_raddr),
      .rd_data(new_rdata)
   );

   cops_sine_acc u_sine_acc (
      .clock     (clock),
      .reset     (reset),
      .ctl       (sine_ctl),
      .phase_self(before_ff),
      .phase_nbr (old_rdata),
      .acc       (acc)
   );

   cops_drift u_drift (
      .clock(clock),
      .ctl  (drift_ctl),
      .gain (gain_ff),
      .acc  (acc),
      .drift(drift)
   );

   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign cnt_done  = (cnt_ff == cops_pkg::CNT_W'(cops_pkg::MAX_OSC));

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      tap_in        = 1'b0;
      cp_pend_in    = 1'b0;
      cp_addr_in    = cp_addr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      before_in     = before_ff;
      rsp_before_in = rsp_before_ff;
      rsp_drift_in  = rsp_drift_ff;
      rsp_after_in  = rsp_after_ff;
      old_we        = 1'b0;
      old_waddr     = idx_ff;
      old_wdata     = noise_ff;
      old_raddr     = idx_ff;
      new_we        = 1'b0;
      new_waddr     = idx_ff;
      new_wdata     = noise_ff;
      new_raddr     = cnt_ff[cops_pkg::IDX_W-1:0];
      sine_ctl.clear = 1'b0;
      sine_ctl.tap   = tap_ff;
      drift_ctl.mul  = 1'b0;
      drift_ctl.rnd  = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            old_we    = 1'b1;
            new_we    = 1'b1;
            old_waddr = cnt_ff[cops_pkg::IDX_W-1:0];
            new_waddr = cnt_ff[cops_pkg::IDX_W-1:0];
            old_wdata = '0;
            new_wdata = '0;
            if (cnt_ff == cops_pkg::CNT_W'(cops_pkg::MAX_OSC - 1)) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + cops_pkg::CNT_W'(1);
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_RD_SELF;
            end
         end
         S_RD_SELF: begin
            state_in = S_GET_SELF;
         end
         S_GET_SELF: begin
            before_in      = idx_ok_ff ? old_rdata : '0;
            sine_ctl.clear = 1'b1;
            cnt_in         = '0;
            state_in       = (idx_ok_ff && mode_ff) ? S_LOOP : S_FINISH;
         end
         S_LOOP: begin
            if (!cnt_done) begin
               old_raddr = cnt_ff[cops_pkg::IDX_W-1:0];
               tap_in    = mask_ff[cnt_ff[cops_pkg::IDX_W-1:0]];
               cnt_in    = cnt_ff + cops_pkg::CNT_W'(1);
            end else begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            drift_ctl.mul = 1'b1;
            state_in      = S_ROUND;
         end
         S_ROUND: begin
            drift_ctl.rnd = 1'b1;
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            rsp_before_in = before_ff;
            rsp_drift_in  = '0;
            rsp_after_in  = '0;
            if (idx_ok_ff) begin
               new_we = 1'b1;
               if (mode_ff) begin
                  rsp_drift_in = drift;
                  rsp_after_in = before_ff + drift + noise_ff;
                  new_wdata    = before_ff + drift + noise_ff;
               end else begin
                  old_we       = 1'b1;
                  rsp_after_in = noise_ff;
               end
            end
            rsp_valid_in = 1'b1;
            cnt_in       = '0;
            state_in     = eos_ff ? S_COPY : S_IDLE;
         end
         S_COPY: begin
            if (!cnt_done) begin
               cp_pend_in = 1'b1;
               cp_addr_in = cnt_ff[cops_pkg::IDX_W-1:0];
               cnt_in     = cnt_ff + cops_pkg::CNT_W'(1);
            end else if (!cp_pend_ff) begin
               state_in = S_IDLE;
            end
            if (cp_pend_ff) begin
               old_we    = 1'b1;
               old_waddr = cp_addr_ff;
               old_wdata = new_rdata;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         tap_ff       <= 1'b0;
         cp_pend_ff   <= 1'b0;
         cp_addr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         gain_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         tap_ff       <= tap_in;
         cp_pend_ff   <= cp_pend_in;
         cp_addr_ff   <= cp_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            gain_ff <= csr_wr_data;
         end
      end
      if (accept) begin
         mode_ff   <= req_mode;
         idx_ff    <= req_osc_index[cops_pkg::IDX_W-1:0];
         idx_ok_ff <= ((cops_pkg::OSC_FIELD_W + 1)'(req_osc_index)
                       < (cops_pkg::OSC_FIELD_W + 1)'(cops_pkg::MAX_OSC));
         noise_ff  <= req_value[cops_pkg::PHASE_W-1:0];
         mask_ff   <= req_neighbor_mask[cops_pkg::MAX_OSC-1:0];
         eos_ff    <= req_end_of_step;
      end
      before_ff     <= before_in;
      rsp_before_ff <= rsp_before_in;
      rsp_drift_ff  <= rsp_drift_in;
      rsp_after_ff  <= rsp_after_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_phase_before = rsp_before_ff;
   assign rsp_drift_step   = rsp_drift_ff;
   assign rsp_phase_after  = rsp_after_ff;

   a_finish_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |-> !rsp_valid_ff)
      else $error("result register still full when a new result is written");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= cops_pkg::CNT_W'(cops_pkg::MAX_OSC))
      else $error("sweep counter beyond oscillator count");

   a_tap_from_loop: assert property (@(posedge clock) disable iff (reset)
      tap_ff |-> $past(state_ff == S_LOOP))
      else $error("sine tap outside the neighbor sweep");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_RD_SELF))
      else $error("transfer did not start the self-phase read");

endmodule
